// ===== src/multichannel_hit_detector_defines.svh =====
// Assertion macros for the hit detector.
`ifndef MULTICHANNEL_HIT_DETECTOR_DEFINES_SVH
`define MULTICHANNEL_HIT_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MHD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hit detector check failed");

// Next-cycle implication, checked out of reset.
`define MHD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hit detector check failed");

`endif

// ===== src/mhd_pkg.sv =====
// Shared constants and codes for the hit detector.
package mhd_pkg;

   localparam int RING_COUNT    = 10;
   localparam int CAPTURE_DEPTH = 64;
   localparam int READING_COUNT = 10;

   localparam int RING_W = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
   localparam int POS_W  = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;

   localparam int ADC_W   = 12;
   localparam int SUM_W   = 32;
   localparam int PROD_W  = 28;
   localparam int MAP_W   = 40;
   localparam int TRIG_W  = 6;
   localparam int CSR_W   = 40;
   localparam int INDEX_W = 3;

   localparam logic [3:0] NONE_CODE = 4'hF;

   // Item actions
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_POLL   = 1'b1;

   // Register indexes
   localparam logic [INDEX_W-1:0] REG_THRESHOLD    = 3'd0;
   localparam logic [INDEX_W-1:0] REG_CONFIRM      = 3'd1;
   localparam logic [INDEX_W-1:0] REG_DEBOUNCE     = 3'd2;
   localparam logic [INDEX_W-1:0] REG_POST_TRIGGER = 3'd3;
   localparam logic [INDEX_W-1:0] REG_RING_MAP     = 3'd4;

   // Detection phases
   localparam logic [1:0] PH_BEFORE = 2'd0;
   localparam logic [1:0] PH_RECORD = 2'd1;
   localparam logic [1:0] PH_AFTER  = 2'd2;

   // Capture phases
   localparam logic [1:0] CAP_IDLE      = 2'd0;
   localparam logic [1:0] CAP_CAPTURING = 2'd1;
   localparam logic [1:0] CAP_READY     = 2'd2;

   localparam logic [11:0] THRESHOLD_RESET    = 12'd150;
   localparam logic [15:0] CONFIRM_RESET      = 16'd1;
   localparam logic [7:0]  DEBOUNCE_RESET     = 8'd1;
   localparam logic [15:0] POST_TRIGGER_RESET = 16'd32;
   localparam logic [MAP_W-1:0] RING_MAP_RESET = 40'd224788615320;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SAMPLE = 4'b0010,
      ST_POLL   = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

endpackage

// ===== src/multichannel_hit_detector.sv =====
// Multichannel strike detector: per-ring energy sums, hit sequencing and poll reporting.
//
// Ten rings each read one of ten 12-bit converter readings through the ring map. A single
// adder and comparator walk the rings one per cycle: a sample item is accepted, then makes
// ten ring passes; a sample ignored while the capture is ready or taken after the hit has
// ended is done on acceptance, and a poll, when the capture is ready, is accepted with the
// product of threshold and confirm factor, makes ten passes for the maximum search and sum
// clear and then loads the result register; otherwise it is accepted and loads the result.
// Input stall is held high until the item is finished; a poll result also waits while the
// previous result is still stalled. Every poll gives one result; samples give none.
`include "multichannel_hit_detector_defines.svh"

module multichannel_hit_detector
   import mhd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [ADC_W-1:0]    req_adc_ch0,
   input  logic [ADC_W-1:0]    req_adc_ch1,
   input  logic [ADC_W-1:0]    req_adc_ch2,
   input  logic [ADC_W-1:0]    req_adc_ch3,
   input  logic [ADC_W-1:0]    req_adc_ch4,
   input  logic [ADC_W-1:0]    req_adc_ch5,
   input  logic [ADC_W-1:0]    req_adc_ch6,
   input  logic [ADC_W-1:0]    req_adc_ch7,
   input  logic [ADC_W-1:0]    req_adc_ch8,
   input  logic [ADC_W-1:0]    req_adc_ch9,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_pending,
   output logic [3:0]          rsp_ring_index,
   output logic [3:0]          rsp_sample_position,
   output logic [TRIG_W-1:0]   rsp_trigger_position,

   input  logic                csr_write,
   input  logic [INDEX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]    csr_data
);

   // Configuration
   logic [11:0]       threshold_ff;
   logic [15:0]       confirm_ff;
   logic [7:0]        debounce_ff;
   logic [15:0]       post_trigger_ff;
   logic [MAP_W-1:0]  ring_map_ff;

   // Sequencer and detection state
   state_type         state_ff, state_in;
   logic [RING_W-1:0] ring_cnt_ff, ring_cnt_in;
   logic              hit_ff, hit_in;
   logic              poll_live_ff, poll_live_in;
   logic [1:0]        detect_ff, detect_in;
   logic [1:0]        capture_ff, capture_in;
   logic [7:0]        quiet_ff, quiet_in;
   logic [15:0]       after_ff, after_in;
   logic [POS_W-1:0]  write_pos_ff, write_pos_in;
   logic [POS_W-1:0]  last_pos_ff, last_pos_in;
   logic [POS_W-1:0]  trigger_mark_ff, trigger_mark_in;

   // Datapath
   logic [ADC_W-1:0]  adc_ff [READING_COUNT];
   logic [SUM_W-1:0]  energy_ff [RING_COUNT];
   logic [SUM_W-1:0]  sum_in;
   logic              sum_we;
   logic [SUM_W-1:0]  best_ff, best_in;
   logic [RING_W-1:0] best_ring_ff, best_ring_in;
   logic [PROD_W-1:0] product_ff, product_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_pending_ff, rsp_pending_in;
   logic [3:0]        rsp_ring_ff, rsp_ring_in;
   logic [3:0]        rsp_pos_ff, rsp_pos_in;
   logic [TRIG_W-1:0] rsp_trig_ff, rsp_trig_in;

   logic              req_accept;
   logic [3:0]        cur_pos;
   logic [ADC_W-1:0]  cur_reading;
   logic              struck;
   logic              last_ring;
   logic              hit_now;
   logic [7:0]        quiet_next;
   logic [15:0]       after_next;
   logic [POS_W-1:0]  write_pos_next;
   logic              confirmed;
   logic              rsp_no_winner;
   logic              ignored_sample;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Shared ring unit: map lookup, threshold compare
   assign cur_pos     = ring_map_ff[{ring_cnt_ff, 2'b00} +: 4];
   assign cur_reading = (cur_pos < 4'(READING_COUNT)) ? adc_ff[cur_pos] : '0;
   assign struck      = cur_reading > threshold_ff;
   assign last_ring   = (ring_cnt_ff == RING_W'(RING_COUNT - 1));
   assign hit_now     = hit_ff || struck;
   assign quiet_next  = quiet_ff + 8'd1;
   assign after_next  = after_ff + 16'd1;
   assign write_pos_next = (write_pos_ff == POS_W'(CAPTURE_DEPTH - 1)) ?
                           '0 : write_pos_ff + POS_W'(1);
   assign confirmed   = poll_live_ff && (best_ff > SUM_W'(product_ff));

   always_comb begin
      state_in        = state_ff;
      ring_cnt_in     = ring_cnt_ff;
      hit_in          = hit_ff;
      poll_live_in    = poll_live_ff;
      detect_in       = detect_ff;
      capture_in      = capture_ff;
      quiet_in        = quiet_ff;
      after_in        = after_ff;
      write_pos_in    = write_pos_ff;
      last_pos_in     = last_pos_ff;
      trigger_mark_in = trigger_mark_ff;
      best_in         = best_ff;
      best_ring_in    = best_ring_ff;
      product_in      = product_ff;
      sum_we          = 1'b0;
      sum_in          = (state_ff == ST_POLL) ? '0 :
                        energy_ff[ring_cnt_ff] + SUM_W'(cur_reading);
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_pending_in  = rsp_pending_ff;
      rsp_ring_in     = rsp_ring_ff;
      rsp_pos_in      = rsp_pos_ff;
      rsp_trig_in     = rsp_trig_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ring_cnt_in = '0;
               if (req_action == ACT_POLL) begin
                  poll_live_in = (capture_ff == CAP_READY);
                  product_in   = PROD_W'(threshold_ff) * PROD_W'(confirm_ff);
                  best_in      = '0;
                  best_ring_in = '0;
                  state_in     = (capture_ff == CAP_READY) ? ST_POLL : ST_RESULT;
               end else if (capture_ff != CAP_READY) begin
                  last_pos_in  = write_pos_ff;
                  write_pos_in = write_pos_next;
                  hit_in       = 1'b0;
                  case (detect_ff) inside
                     PH_BEFORE, PH_RECORD: state_in = ST_SAMPLE;
                     PH_AFTER: begin
                        if (capture_ff == CAP_CAPTURING) begin
                           after_in = after_next;
                           if (after_next >= post_trigger_ff)
                              capture_in = CAP_READY;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         ST_SAMPLE: begin
            // Before a hit only the first struck ring adds
            sum_we = struck && ((detect_ff == PH_RECORD) || !hit_ff);
            hit_in = hit_now;
            if (last_ring) begin
               state_in = ST_IDLE;
               if (detect_ff == PH_BEFORE) begin
                  if (hit_now) begin
                     detect_in = PH_RECORD;
                     quiet_in  = '0;
                     if (capture_ff == CAP_IDLE) begin
                        trigger_mark_in = last_pos_ff;
                        capture_in      = CAP_CAPTURING;
                        after_in        = '0;
                     end
                  end
               end else if (hit_now) begin
                  quiet_in = '0;
               end else begin
                  quiet_in = quiet_next;
                  if (quiet_next >= debounce_ff)
                     detect_in = PH_AFTER;
               end
            end else begin
               ring_cnt_in = ring_cnt_ff + RING_W'(1);
            end
         end
         ST_POLL: begin
            // Search the maximum and clear each sum as it is passed
            sum_we = 1'b1;
            if (energy_ff[ring_cnt_ff] > best_ff) begin
               best_in      = energy_ff[ring_cnt_ff];
               best_ring_in = ring_cnt_ff;
            end
            if (last_ring) begin
               state_in   = ST_RESULT;
               capture_in = CAP_IDLE;
               after_in   = '0;
               detect_in  = PH_BEFORE;
            end else begin
               ring_cnt_in = ring_cnt_ff + RING_W'(1);
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_pending_in = confirmed;
               rsp_ring_in    = confirmed ? 4'(best_ring_ff) : NONE_CODE;
               rsp_pos_in     = confirmed ? ring_map_ff[{best_ring_ff, 2'b00} +: 4] : NONE_CODE;
               rsp_trig_in    = TRIG_W'(trigger_mark_ff);
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ring_cnt_ff     <= '0;
         hit_ff          <= 1'b0;
         poll_live_ff    <= 1'b0;
         detect_ff       <= PH_BEFORE;
         capture_ff      <= CAP_IDLE;
         quiet_ff        <= '0;
         after_ff        <= '0;
         write_pos_ff    <= '0;
         last_pos_ff     <= '0;
         trigger_mark_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         ring_cnt_ff     <= ring_cnt_in;
         hit_ff          <= hit_in;
         poll_live_ff    <= poll_live_in;
         detect_ff       <= detect_in;
         capture_ff      <= capture_in;
         quiet_ff        <= quiet_in;
         after_ff        <= after_in;
         write_pos_ff    <= write_pos_in;
         last_pos_ff     <= last_pos_in;
         trigger_mark_ff <= trigger_mark_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      best_ff        <= best_in;
      best_ring_ff   <= best_ring_in;
      product_ff     <= product_in;
      rsp_pending_ff <= rsp_pending_in;
      rsp_ring_ff    <= rsp_ring_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_trig_ff    <= rsp_trig_in;
      if (req_accept) begin
         adc_ff[0] <= req_adc_ch0;
         adc_ff[1] <= req_adc_ch1;
         adc_ff[2] <= req_adc_ch2;
         adc_ff[3] <= req_adc_ch3;
         adc_ff[4] <= req_adc_ch4;
         adc_ff[5] <= req_adc_ch5;
         adc_ff[6] <= req_adc_ch6;
         adc_ff[7] <= req_adc_ch7;
         adc_ff[8] <= req_adc_ch8;
         adc_ff[9] <= req_adc_ch9;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_COUNT; i++)
            energy_ff[i] <= '0;
      end else if (sum_we) begin
         energy_ff[ring_cnt_ff] <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         confirm_ff      <= CONFIRM_RESET;
         debounce_ff     <= DEBOUNCE_RESET;
         post_trigger_ff <= POST_TRIGGER_RESET;
         ring_map_ff     <= RING_MAP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_THRESHOLD:    threshold_ff    <= csr_data[11:0];
            REG_CONFIRM:      confirm_ff      <= csr_data[15:0];
            REG_DEBOUNCE:     debounce_ff     <= csr_data[7:0];
            REG_POST_TRIGGER: post_trigger_ff <= csr_data[15:0];
            REG_RING_MAP:     ring_map_ff     <= csr_data[MAP_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pending          = rsp_pending_ff;
   assign rsp_ring_index       = rsp_ring_ff;
   assign rsp_sample_position  = rsp_pos_ff;
   assign rsp_trigger_position = rsp_trig_ff;

   assign rsp_no_winner  = (rsp_ring_index == NONE_CODE) && (rsp_sample_position == NONE_CODE);
   assign ignored_sample = req_accept && (req_action == ACT_SAMPLE) && (capture_ff == CAP_READY);

   `MHD_ASSERT_NOW(a_ready_after_hit, capture_ff == CAP_READY, detect_ff == PH_AFTER)
   `MHD_ASSERT_NOW(a_idle_before_hit, capture_ff == CAP_IDLE, detect_ff == PH_BEFORE)
   `MHD_ASSERT_NOW(a_none_unless_pending, rsp_valid && !rsp_pending, rsp_no_winner)
   `MHD_ASSERT_NEXT(a_ready_holds_position, ignored_sample, $stable(write_pos_ff))

endmodule

// ===== tb/multichannel_hit_detector_checker.sv =====
// Scoreboard for the hit detector: mirrors its state from the channels and checks every poll report.
`timescale 1ns / 100ps

module multichannel_hit_detector_checker
   import mhd_pkg::*;
(
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_action,
   input  logic [READING_COUNT-1:0][ADC_W-1:0] req_adc,

   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_pending,
   input  logic [3:0]                          rsp_ring_index,
   input  logic [3:0]                          rsp_sample_position,
   input  logic [TRIG_W-1:0]                   rsp_trigger_position,

   input  logic                                csr_write,
   input  logic [INDEX_W-1:0]                  csr_index,
   input  logic [CSR_W-1:0]                    csr_data,

   output int                                  mismatch_count,
   output int                                  reports_due
);

   typedef struct packed {
      logic              pending;
      logic [3:0]        ring_index;
      logic [3:0]        sample_position;
      logic [TRIG_W-1:0] trigger_position;
   } hit_report_type;

   // Register copies
   logic [ADC_W-1:0]  threshold;
   logic [15:0]       confirm_factor;
   logic [7:0]        quiet_debounce;
   logic [15:0]       post_trigger;
   logic [MAP_W-1:0]  ring_map;

   // Detector state
   logic [1:0]        detect_phase;
   logic [1:0]        capture_phase;
   logic [SUM_W-1:0]  energy [RING_COUNT];
   logic [7:0]        quiet_count;
   logic [15:0]       after_count;
   logic [POS_W-1:0]  write_position;
   logic [POS_W-1:0]  trigger_mark;

   hit_report_type    reports_queue [$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s mismatch, got %0d, want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Reading that a ring sees; positions past the converters read zero.
   function automatic logic [ADC_W-1:0] ring_level(
      input logic [READING_COUNT-1:0][ADC_W-1:0] adc, input int ring);
      logic [3:0] pos;
      pos = ring_map[4*ring +: 4];
      if (pos >= READING_COUNT) begin
         return '0;
      end
      return adc[pos];
   endfunction

   task automatic clear_detector();
      threshold      = THRESHOLD_RESET;
      confirm_factor = CONFIRM_RESET;
      quiet_debounce = DEBOUNCE_RESET;
      post_trigger   = POST_TRIGGER_RESET;
      ring_map       = RING_MAP_RESET;
      detect_phase   = PH_BEFORE;
      capture_phase  = CAP_IDLE;
      for (int i = 0; i < RING_COUNT; i++) begin
         energy[i] = '0;
      end
      quiet_count    = '0;
      after_count    = '0;
      write_position = '0;
      trigger_mark   = '0;
   endtask

   task automatic take_register(input logic [INDEX_W-1:0] index, input logic [CSR_W-1:0] value);
      case (index)
         REG_THRESHOLD:    threshold = value[ADC_W-1:0];
         REG_CONFIRM:      confirm_factor = value[15:0];
         REG_DEBOUNCE:     quiet_debounce = value[7:0];
         REG_POST_TRIGGER: post_trigger = value[15:0];
         REG_RING_MAP:     ring_map = value[MAP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic absorb_sample(input logic [READING_COUNT-1:0][ADC_W-1:0] adc);
      logic [POS_W-1:0] last;
      logic [ADC_W-1:0] level;
      logic             struck;
      struck = 1'b0;
      if (capture_phase != CAP_READY) begin
         last = write_position;
         write_position = POS_W'((write_position + 1'b1) % CAPTURE_DEPTH);
         case (detect_phase)
            PH_BEFORE: begin
               // only the first ring over the threshold arms the hit
               for (int i = 0; i < RING_COUNT && !struck; i++) begin
                  level = ring_level(adc, i);
                  if (level > threshold) begin
                     energy[i] = energy[i] + level;
                     struck = 1'b1;
                     detect_phase = PH_RECORD;
                     quiet_count = '0;
                     if (capture_phase == CAP_IDLE) begin
                        trigger_mark = last;
                        capture_phase = CAP_CAPTURING;
                        after_count = '0;
                     end
                  end
               end
            end
            PH_RECORD: begin
               for (int i = 0; i < RING_COUNT; i++) begin
                  level = ring_level(adc, i);
                  if (level > threshold) begin
                     energy[i] = energy[i] + level;
                     struck = 1'b1;
                  end
               end
               if (struck) begin
                  quiet_count = '0;
               end else begin
                  quiet_count = quiet_count + 1'b1;
                  if (quiet_count >= quiet_debounce) begin
                     detect_phase = PH_AFTER;
                  end
               end
            end
            PH_AFTER: begin
               if (capture_phase == CAP_CAPTURING) begin
                  after_count = after_count + 1'b1;
                  if (after_count >= post_trigger) begin
                     capture_phase = CAP_READY;
                  end
               end
            end
            default: ;
         endcase
      end
   endtask

   task automatic answer_poll(output hit_report_type report);
      logic [SUM_W-1:0] best;
      logic [63:0]      bar;
      int               best_ring;
      report.pending          = 1'b0;
      report.ring_index       = NONE_CODE;
      report.sample_position  = NONE_CODE;
      report.trigger_position = trigger_mark;
      if (capture_phase == CAP_READY) begin
         best = '0;
         best_ring = 0;
         capture_phase = CAP_IDLE;
         after_count = '0;
         // strict compare keeps the lowest ring on a tie
         for (int i = 0; i < RING_COUNT; i++) begin
            if (energy[i] > best) begin
               best = energy[i];
               best_ring = i;
            end
            energy[i] = '0;
         end
         bar = threshold * confirm_factor;
         if (best > bar) begin
            report.pending         = 1'b1;
            report.ring_index      = 4'(best_ring);
            report.sample_position = ring_map[4*best_ring +: 4];
         end
         detect_phase = PH_BEFORE;
      end
   endtask

   always @(posedge clock) begin : watch
      hit_report_type want;
      if (reset) begin
         clear_detector();
         reports_queue.delete();
      end else begin
         if (csr_write) begin
            take_register(csr_index, csr_data);
         end
         // check the outgoing report before queueing any new poll
         if (rsp_valid && !rsp_stall) begin
            if (reports_queue.size() == 0) begin
               report_mismatch("unexpected report", 1, 0);
            end else begin
               want = reports_queue.pop_front();
               if (rsp_pending !== want.pending)
                  report_mismatch("pending", rsp_pending, want.pending);
               if (rsp_ring_index !== want.ring_index)
                  report_mismatch("ring_index", rsp_ring_index, want.ring_index);
               if (rsp_sample_position !== want.sample_position)
                  report_mismatch("sample_position", rsp_sample_position,
                                  want.sample_position);
               if (rsp_trigger_position !== want.trigger_position)
                  report_mismatch("trigger_position", rsp_trigger_position,
                                  want.trigger_position);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_action == ACT_POLL) begin
               answer_poll(want);
               reports_queue.push_back(want);
            end else begin
               absorb_sample(req_adc);
            end
         end
      end
      reports_due <= reports_queue.size();
   end

endmodule

// ===== tb/multichannel_hit_detector_test.sv =====
// Top of the hit detector testbench: clock, reset, stimulus phases and the verdict.
`timescale 1ns / 100ps

module multichannel_hit_detector_test
   import mhd_pkg::*;
();

   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int RANDOM_ITEMS    = 760;
   localparam int PHASE_COUNT     = 12;

   localparam logic [ADC_W-1:0] LEVEL_MAX      = '1;
   localparam logic [MAP_W-1:0] MAP_ALL_NONE   = '1;
   localparam logic [MAP_W-1:0] MAP_RING1_ONLY = 40'hFF_FFFF_FF0F;

   typedef logic [READING_COUNT-1:0][ADC_W-1:0] reading_set_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_action;
   reading_set_type     req_adc;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_pending;
   logic [3:0]          rsp_ring_index;
   logic [3:0]          rsp_sample_position;
   logic [TRIG_W-1:0]   rsp_trigger_position;
   logic                csr_write;
   logic [INDEX_W-1:0]  csr_index;
   logic [CSR_W-1:0]    csr_data;

   int                  mismatch_count;
   int                  reports_due;

   int                  idle_pct = 0;
   int                  stall_pct = 0;
   int                  hold_off_bursts = 0;
   int                  items_sent = 0;
   int                  cycle_count = 0;
   logic [ADC_W-1:0]    cur_threshold;
   int                  cur_debounce;
   int                  cur_post;

   multichannel_hit_detector u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_adc_ch0          (req_adc[0]),
      .req_adc_ch1          (req_adc[1]),
      .req_adc_ch2          (req_adc[2]),
      .req_adc_ch3          (req_adc[3]),
      .req_adc_ch4          (req_adc[4]),
      .req_adc_ch5          (req_adc[5]),
      .req_adc_ch6          (req_adc[6]),
      .req_adc_ch7          (req_adc[7]),
      .req_adc_ch8          (req_adc[8]),
      .req_adc_ch9          (req_adc[9]),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pending          (rsp_pending),
      .rsp_ring_index       (rsp_ring_index),
      .rsp_sample_position  (rsp_sample_position),
      .rsp_trigger_position (rsp_trigger_position),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   multichannel_hit_detector_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_adc              (req_adc),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pending          (rsp_pending),
      .rsp_ring_index       (rsp_ring_index),
      .rsp_sample_position  (rsp_sample_position),
      .rsp_trigger_position (rsp_trigger_position),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .mismatch_count       (mismatch_count),
      .reports_due          (reports_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Result side: random stall, or a long hold-off when one is requested.
   initial begin : receiver
      int hold_left;
      int bursts_seen;
      hold_left = 0;
      bursts_seen = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_off_bursts != bursts_seen) begin
            hold_left = HOLD_OFF_CYCLES;
            bursts_seen = hold_off_bursts;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   function automatic reading_set_type flat_set(input logic [ADC_W-1:0] level);
      reading_set_type readings;
      for (int i = 0; i < READING_COUNT; i++) begin
         readings[i] = level;
      end
      return readings;
   endfunction

   function automatic reading_set_type quiet_set();
      reading_set_type readings;
      for (int i = 0; i < READING_COUNT; i++) begin
         readings[i] = ADC_W'($urandom_range(cur_threshold));
      end
      return readings;
   endfunction

   function automatic reading_set_type loud_set();
      reading_set_type readings;
      for (int i = 0; i < READING_COUNT; i++) begin
         if (cur_threshold != LEVEL_MAX && $urandom_range(1) == 1) begin
            readings[i] = ADC_W'($urandom_range(LEVEL_MAX, cur_threshold + 1));
         end else begin
            readings[i] = ADC_W'($urandom_range(cur_threshold));
         end
      end
      return readings;
   endfunction

   function automatic reading_set_type noise_set();
      reading_set_type readings;
      for (int i = 0; i < READING_COUNT; i++) begin
         readings[i] = ADC_W'($urandom());
      end
      return readings;
   endfunction

   // Offer one item after an optional gap and hold it until accepted.
   task automatic send_item(input logic action, input reading_set_type readings);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= action;
      req_adc    <= readings;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid and wait until every report is back and the last sample has gone through.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [CSR_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [ADC_W-1:0] thr, input logic [15:0] confirm,
                            input logic [7:0] debounce, input logic [15:0] post,
                            input logic [MAP_W-1:0] map);
      write_reg(REG_THRESHOLD, CSR_W'(thr));
      write_reg(REG_CONFIRM, CSR_W'(confirm));
      write_reg(REG_DEBOUNCE, CSR_W'(debounce));
      write_reg(REG_POST_TRIGGER, CSR_W'(post));
      write_reg(REG_RING_MAP, map);
      csr_write <= 1'b0;
      cur_threshold = thr;
      cur_debounce  = int'(debounce);
      cur_post      = int'(post);
   endtask

   task automatic pick_settings();
      logic [ADC_W-1:0] thr;
      logic [15:0]      confirm;
      logic [7:0]       debounce;
      logic [15:0]      post;
      logic [MAP_W-1:0] map;
      logic [3:0]       nib;
      case ($urandom_range(9))
         0:       thr = '0;
         1:       thr = LEVEL_MAX;
         default: thr = ADC_W'($urandom_range(3000, 20));
      endcase
      case ($urandom_range(7))
         0:       confirm = '0;
         1:       confirm = '1;
         2:       confirm = 16'($urandom_range(16'hFFFF));
         default: confirm = 16'($urandom_range(8));
      endcase
      debounce = ($urandom_range(11) == 0) ? 8'hFF : 8'($urandom_range(4));
      post = ($urandom_range(11) == 0) ? 16'hFFFF : 16'($urandom_range(6));
      map = '0;
      for (int i = 0; i < RING_COUNT; i++) begin
         nib = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
         map[4*i +: 4] = nib;
      end
      if ($urandom_range(5) == 0) begin
         map = MAP_W'({$urandom(), $urandom()});
      end
      configure(thr, confirm, debounce, post, map);
   endtask

   // One strike: loud samples, a quiet run, the post-trigger tail and a poll.
   task automatic run_hit();
      int loud_n;
      int quiet_n;
      int tail_n;
      loud_n  = $urandom_range(4, 1);
      quiet_n = ((cur_debounce > 6) ? 6 : cur_debounce) + $urandom_range(1);
      tail_n  = ((cur_post > 6) ? 6 : cur_post) + $urandom_range(2);
      repeat (loud_n) send_item(ACT_SAMPLE, loud_set());
      if ($urandom_range(3) == 0) begin
         send_item(ACT_POLL, noise_set());
      end
      repeat (quiet_n) begin
         send_item(ACT_SAMPLE, ($urandom_range(7) == 0) ? loud_set() : quiet_set());
      end
      repeat (tail_n) begin
         send_item(ACT_SAMPLE, ($urandom_range(1) == 1) ? noise_set() : quiet_set());
      end
      send_item(ACT_POLL, noise_set());
   endtask

   // Hold the result side off and keep polling so the block backs up.
   task automatic hold_off_burst();
      hold_off_bursts++;
      repeat (30) send_item(ACT_POLL, noise_set());
   endtask

   initial begin : stimulus
      reading_set_type spot;
      int              pick;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_action <= ACT_SAMPLE;
      req_adc    <= '0;
      csr_write  <= 1'b0;
      csr_index  <= REG_THRESHOLD;
      csr_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // immediate ends: first quiet sample ends the hit, first tail sample makes it ready
      configure(THRESHOLD_RESET, CONFIRM_RESET, 8'd0, 16'd0, RING_MAP_RESET);
      send_item(ACT_POLL, flat_set('0));
      send_item(ACT_SAMPLE, flat_set(LEVEL_MAX));
      spot = flat_set('0);
      spot[1] = 12'd500;
      spot[6] = 12'd500;
      send_item(ACT_SAMPLE, spot);
      send_item(ACT_SAMPLE, flat_set('0));
      send_item(ACT_SAMPLE, flat_set('0));
      send_item(ACT_SAMPLE, flat_set(LEVEL_MAX));
      send_item(ACT_POLL, flat_set(LEVEL_MAX));
      // tie between two rings: lower index must win
      spot = flat_set('0);
      spot[1] = 12'd500;
      send_item(ACT_SAMPLE, spot);
      spot = flat_set('0);
      spot[6] = 12'd500;
      send_item(ACT_SAMPLE, spot);
      send_item(ACT_SAMPLE, flat_set('0));
      send_item(ACT_SAMPLE, flat_set('0));
      send_item(ACT_POLL, flat_set('0));
      settle();

      // every ring off the converters, all limits at their top
      configure(LEVEL_MAX, 16'hFFFF, 8'hFF, 16'hFFFF, MAP_ALL_NONE);
      send_item(ACT_SAMPLE, flat_set(LEVEL_MAX));
      send_item(ACT_POLL, flat_set(LEVEL_MAX));
      settle();

      // zero threshold and factor; ring 0 reads nothing, ring 1 takes the strike
      configure('0, 16'd0, 8'd2, 16'd1, MAP_RING1_ONLY);
      send_item(ACT_SAMPLE, flat_set(LEVEL_MAX));
      send_item(ACT_SAMPLE, flat_set('0));
      send_item(ACT_SAMPLE, flat_set('0));
      send_item(ACT_SAMPLE, flat_set('0));
      send_item(ACT_POLL, flat_set('0));
      settle();

      // hit too weak to confirm, then a poll with nothing ready
      configure(THRESHOLD_RESET, 16'hFFFF, 8'd1, 16'd0, RING_MAP_RESET);
      send_item(ACT_SAMPLE, flat_set(12'd200));
      send_item(ACT_SAMPLE, flat_set('0));
      send_item(ACT_SAMPLE, flat_set('0));
      send_item(ACT_POLL, flat_set('0));
      send_item(ACT_POLL, flat_set('0));
      settle();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase
         pick_settings();
         if (phase == 5) begin
            hold_off_burst();
         end
         while (items_sent < 24 + (phase + 1) * RANDOM_ITEMS / PHASE_COUNT) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               run_hit();
            end else if (pick < 88) begin
               send_item(ACT_SAMPLE, noise_set());
            end else begin
               send_item(ACT_POLL, noise_set());
            end
         end
         settle();
      end

      if (mismatch_count == 0 && reports_due == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
